### hw/rtl/mbe_pkg.sv
// Package for the Mandelbrot escape-time counter.
// Holds fixed-point widths, register codes, reset values and saturation helpers.
// No dependencies.
package mbe_pkg;

	localparam int unsigned FRAC_BITS = 28;
	localparam int unsigned MAX_DIM = 4096;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned PROD_W = 2 * WORD_W;
	localparam int unsigned PIX_W = 12;
	localparam int unsigned CNT_W = 24;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned IDX_W = 3;

	localparam int unsigned SQ_W = PROD_W - 1 - FRAC_BITS;
	localparam int unsigned CMP_W = (SQ_W + 1 > FRAC_BITS + 3) ? SQ_W + 1 : FRAC_BITS + 3;
	localparam int unsigned ACC_W = PROD_W + 2;

	localparam logic [CMP_W-1:0] FOUR = {{(CMP_W-1){1'b0}}, 1'b1} << (FRAC_BITS + 2);

	localparam logic [IDX_W-1:0] REG_X_ORIGIN = 3'd0;
	localparam logic [IDX_W-1:0] REG_X_STEP = 3'd1;
	localparam logic [IDX_W-1:0] REG_Y_ORIGIN = 3'd2;
	localparam logic [IDX_W-1:0] REG_Y_STEP = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_ITER = 3'd4;

	localparam logic [WORD_W-1:0] RST_X_ORIGIN = 32'hE000_0000;
	localparam logic [WORD_W-1:0] RST_X_STEP = 32'h0004_0000;
	localparam logic [WORD_W-1:0] RST_Y_ORIGIN = 32'hF000_0000;
	localparam logic [WORD_W-1:0] RST_Y_STEP = 32'h0004_0000;
	localparam logic [CNT_W-1:0] RST_MAX_ITER = 24'd10000;

	function automatic logic signed [ACC_W-1:0] ext_word(input logic signed [WORD_W-1:0] v);
		return {{(ACC_W-WORD_W){v[WORD_W-1]}}, v};
	endfunction

	function automatic logic signed [ACC_W-1:0] ext_prod(input logic signed [PROD_W-1:0] v);
		return {{(ACC_W-PROD_W){v[PROD_W-1]}}, v};
	endfunction

	function automatic logic signed [ACC_W-1:0] ext_sq(input logic [SQ_W-1:0] v);
		return signed'({{(ACC_W-SQ_W){1'b0}}, v});
	endfunction

	// Clamps a wide signed value to the signed word range.
	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
		logic signed [WORD_W-1:0] r;
		if (&v[ACC_W-1:WORD_W-1] || ~|v[ACC_W-1:WORD_W-1]) begin
			r = v[WORD_W-1:0];
		end else if (v[ACC_W-1]) begin
			r = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(WORD_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

### hw/rtl/mandelbrot_escape_counter.sv
// Top level of the Mandelbrot escape-time counter: register file, sequencer
// and one shared 32x32 signed multiplier. Depends on mbe_pkg.
//
// Channel   | Handshake                       | Payload
// ----------+---------------------------------+----------------------------------------
// config    | psel/penable/pwrite, pready = 1 | paddr, pwdata, prdata
// pixel in  | start while busy is low         | pixel_column, pixel_row, last_pixel
// result    | done, one cycle                 | escape_count, out_column, out_row, last
//
// After acceptance an item passes the wrap, cx multiply, cy multiply and load states,
// then the x*y, x*x, y*y and check states once per update, and ends in done.
// The single multiplier serves the cx and cy products, x*y, x*x and y*y in turn.
// Busy stays high from acceptance through the done cycle.
// Reset restores the register defaults and returns the sequencer to idle.
// The result cannot be stalled; done is high for exactly one cycle.
module mandelbrot_escape_counter
	import mbe_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [WORD_W-1:0]       pwdata,
	output logic [WORD_W-1:0]       prdata,
	output logic                    pready,
	input  logic                    start,
	output logic                    busy,
	input  logic [PIX_W-1:0]        pixel_column,
	input  logic [PIX_W-1:0]        pixel_row,
	input  logic                    last_pixel,
	output logic                    done,
	output logic [CNT_W-1:0]        escape_count,
	output logic [PIX_W-1:0]        out_column,
	output logic [PIX_W-1:0]        out_row,
	output logic                    last
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_WRAP   = 4'd1;
	localparam logic [3:0] ST_MUL_CX = 4'd2;
	localparam logic [3:0] ST_MUL_CY = 4'd3;
	localparam logic [3:0] ST_LOAD   = 4'd4;
	localparam logic [3:0] ST_IT_XY  = 4'd5;
	localparam logic [3:0] ST_IT_XX  = 4'd6;
	localparam logic [3:0] ST_IT_YY  = 4'd7;
	localparam logic [3:0] ST_IT_CHK = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	logic [3:0] state_q;

	logic signed [WORD_W-1:0] x_origin_q;
	logic signed [WORD_W-1:0] x_step_q;
	logic signed [WORD_W-1:0] y_origin_q;
	logic signed [WORD_W-1:0] y_step_q;
	logic [CNT_W-1:0]         max_iter_q;

	logic [PIX_W-1:0] col_q;
	logic [PIX_W-1:0] row_q;
	logic             last_q;
	logic [PIX_W-1:0] colw_q;
	logic [PIX_W-1:0] roww_q;

	logic signed [WORD_W-1:0] cx_q;
	logic signed [WORD_W-1:0] cy_q;
	logic signed [WORD_W-1:0] x_q;
	logic signed [WORD_W-1:0] y_q;
	logic [SQ_W-1:0]          xx_q;
	logic [SQ_W-1:0]          yy_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [WORD_W-1:0] mul_a;
	logic signed [WORD_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] xy2;
	logic signed [PROD_W-1:0] sq_full;
	logic [SQ_W-1:0]          sq_new;
	logic signed [WORD_W-1:0] cx_next;
	logic signed [WORD_W-1:0] cy_next;
	logic signed [WORD_W-1:0] nx;
	logic signed [WORD_W-1:0] ny;
	logic [CMP_W-1:0]         mag;
	logic [CNT_W-1:0]         count_inc;
	logic                     escaped;
	logic                     at_limit;
	logic                     col_big;
	logic                     row_big;
	logic                     cfg_wr;
	logic [IDX_W-1:0]         cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = paddr[ADDR_W-1:2];

	always_comb begin
		unique case (cfg_idx)
			REG_X_ORIGIN: prdata = x_origin_q;
			REG_X_STEP:   prdata = x_step_q;
			REG_Y_ORIGIN: prdata = y_origin_q;
			REG_Y_STEP:   prdata = y_step_q;
			REG_MAX_ITER: prdata = {{(WORD_W-CNT_W){1'b0}}, max_iter_q};
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_MUL_CX: begin
				mul_a = signed'({{(WORD_W-PIX_W){1'b0}}, colw_q});
				mul_b = x_step_q;
			end
			ST_MUL_CY: begin
				mul_a = signed'({{(WORD_W-PIX_W){1'b0}}, roww_q});
				mul_b = y_step_q;
			end
			ST_IT_XY: begin
				mul_a = x_q;
				mul_b = y_q;
			end
			ST_IT_XX: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			ST_IT_YY: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign cx_next = sat_word(ext_word(x_origin_q) + ext_prod(prod_q));
	assign cy_next = sat_word(ext_word(y_origin_q) + ext_prod(prod_q));
	assign nx = sat_word(ext_sq(xx_q) - ext_sq(yy_q) + ext_word(cx_q));
	assign xy2 = prod_q >>> (FRAC_BITS - 1);
	assign ny = sat_word(ext_prod(xy2) + ext_word(cy_q));
	assign sq_full = prod_q >>> FRAC_BITS;
	assign sq_new = sq_full[SQ_W-1:0];
	assign mag = CMP_W'(xx_q) + CMP_W'(sq_new);
	assign count_inc = count_q + 1'b1;
	assign escaped = mag >= FOUR;
	assign at_limit = count_inc >= max_iter_q;
	assign col_big = {{(WORD_W-PIX_W){1'b0}}, colw_q} >= WORD_W'(MAX_DIM);
	assign row_big = {{(WORD_W-PIX_W){1'b0}}, roww_q} >= WORD_W'(MAX_DIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			x_origin_q <= RST_X_ORIGIN;
			x_step_q <= RST_X_STEP;
			y_origin_q <= RST_Y_ORIGIN;
			y_step_q <= RST_Y_STEP;
			max_iter_q <= RST_MAX_ITER;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_X_ORIGIN: x_origin_q <= pwdata;
					REG_X_STEP:   x_step_q <= pwdata;
					REG_Y_ORIGIN: y_origin_q <= pwdata;
					REG_Y_STEP:   y_step_q <= pwdata;
					REG_MAX_ITER: max_iter_q <= pwdata[CNT_W-1:0];
					default:      ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					if (!col_big && !row_big) state_q <= ST_MUL_CX;
				end
				ST_MUL_CX: state_q <= ST_MUL_CY;
				ST_MUL_CY: state_q <= ST_LOAD;
				ST_LOAD: begin
					state_q <= (max_iter_q == '0) ? ST_DONE : ST_IT_XY;
				end
				ST_IT_XY:  state_q <= ST_IT_XX;
				ST_IT_XX:  state_q <= ST_IT_YY;
				ST_IT_YY:  state_q <= ST_IT_CHK;
				ST_IT_CHK: begin
					state_q <= (escaped || at_limit) ? ST_DONE : ST_IT_XY;
				end
				ST_DONE:   state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					col_q <= pixel_column;
					row_q <= pixel_row;
					last_q <= last_pixel;
					colw_q <= pixel_column;
					roww_q <= pixel_row;
				end
			end
			ST_WRAP: begin
				if (col_big) colw_q <= colw_q - PIX_W'(MAX_DIM);
				if (row_big) roww_q <= roww_q - PIX_W'(MAX_DIM);
			end
			ST_MUL_CY: cx_q <= cx_next;
			ST_LOAD: begin
				cy_q <= cy_next;
				x_q <= '0;
				y_q <= '0;
				xx_q <= '0;
				yy_q <= '0;
				count_q <= '0;
			end
			ST_IT_XY:  x_q <= nx;
			ST_IT_XX:  y_q <= ny;
			ST_IT_YY:  xx_q <= sq_new;
			ST_IT_CHK: begin
				yy_q <= sq_new;
				count_q <= count_inc;
			end
			default: ;
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_DONE;
	assign escape_count = count_q;
	assign out_column = col_q;
	assign out_row = row_q;
	assign last = last_q;

	ap_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("Result strobe lasted more than one cycle.");

	ap_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("Accepted item did not raise busy.");

	ap_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("Result strobe outside a busy period.");

	ap_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> escape_count <= max_iter_q)
		else $error("Escape count exceeds the iteration limit.");

	ap_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && escape_count == '0 |-> max_iter_q == '0)
		else $error("Zero escape count with a nonzero limit.");

endmodule
